>>> hdl/txn_read_write_set_tracker_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the read/write set tracker
// Shared immediate-style wrappers around concurrent properties on clk/arst_n.
// ----------------------------------------------------------------------------
`ifndef TXN_READ_WRITE_SET_TRACKER_MACROS_SVH
`define TXN_READ_WRITE_SET_TRACKER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define RWSET_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define RWSET_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/rwset_pkg.sv
// ----------------------------------------------------------------------------
// rwset_pkg
// Types, codes and sizes shared by the read/write set tracker.
// ----------------------------------------------------------------------------
package rwset_pkg;

	localparam int SET_CAPACITY = 64;
	localparam int IDX_W        = $clog2(SET_CAPACITY);
	localparam int CNT_W        = $clog2(SET_CAPACITY + 1);
	localparam int KEY_W        = 64;

	typedef enum logic [2:0] {
		OP_QUERY  = 3'd0,
		OP_READ   = 3'd1,
		OP_UPDATE = 3'd2,
		OP_INSERT = 3'd3,
		OP_DELETE = 3'd4,
		OP_CLEAR  = 3'd5
	} op_t;

	typedef enum logic [2:0] {
		KIND_ABSENT   = 3'd0,
		KIND_READ     = 3'd1,
		KIND_READ_OWN = 3'd2,
		KIND_UPDATE   = 3'd3,
		KIND_INSERT   = 3'd4,
		KIND_DELETE   = 3'd5,
		KIND_INS_DEL  = 3'd6
	} kind_t;

	typedef enum logic [1:0] {
		ERR_NONE    = 2'd0,
		ERR_ILLEGAL = 2'd1,
		ERR_FULL    = 2'd2
	} err_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_DECIDE
	} state_t;

	typedef struct packed {
		logic [2:0]       op;
		logic [KEY_W-1:0] record_key;
	} cmd_t;

	typedef struct packed {
		logic       added;
		kind_t      kind_before;
		kind_t      kind_after;
		err_t       error_code;
		logic [6:0] inserts_pending;
		logic       written_flag;
	} rsp_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		kind_t            kind;
	} entry_t;

	typedef struct packed {
		logic             re;
		logic [IDX_W-1:0] raddr;
		logic             we;
		logic [IDX_W-1:0] waddr;
		entry_t           wdata;
	} mem_req_t;

endpackage

>>> hdl/txn_read_write_set_tracker.sv
// ----------------------------------------------------------------------------
// txn_read_write_set_tracker
// Read/write set of one transaction: record key -> access kind, RAM based.
// ----------------------------------------------------------------------------
// Sequence: after the accepting edge the key is compared with one entry at
//   a time from slot 0 until a hit or the last live entry (none when the set
//   is empty), then the decide state writes back; done is registered from it.
// Flow: busy holds off new transactions until done; results cannot be stalled.
// Reset: set empty (fill count 0), insert count 0, written flag 1. No RAM
//   clearing pass; the fill count alone marks valid entries.
module txn_read_write_set_tracker (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  rwset_pkg::cmd_t cmd,
	output logic            done,
	output rwset_pkg::rsp_t result
);
	import rwset_pkg::*;

	// Sequencer <-> entry RAM. Each entry holds the key and its access kind;
	// entries [0, count) are live, new keys are appended at the fill count.
	mem_req_t             mem_req;
	entry_t               mem_rdata;
	logic [$bits(entry_t)-1:0] ram_rdata;

	// The sequencer probes one entry per cycle, compares the 64-bit key,
	// then applies the kind transition and writes the entry back. busy stays
	// high through the write so no probe can race the write-back.
	rwset_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.done      (done),
		.result    (result),
		.mem_req   (mem_req),
		.mem_rdata (mem_rdata)
	);

	assign mem_rdata = entry_t'(ram_rdata);

	rwset_entry_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (SET_CAPACITY)
	) u_entry_ram (
		.clk   (clk),
		.we    (mem_req.we),
		.waddr (mem_req.waddr),
		.wdata (mem_req.wdata),
		.re    (mem_req.re),
		.raddr (mem_req.raddr),
		.rdata (ram_rdata)
	);

endmodule

>>> hdl/rwset_entry_ram.sv
// ----------------------------------------------------------------------------
// rwset_entry_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module rwset_entry_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> hdl/rwset_ctrl.sv
// ----------------------------------------------------------------------------
// rwset_ctrl
// Sequencer: linear key probe over the entry RAM, then kind update/write-back.
// ----------------------------------------------------------------------------
module rwset_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  rwset_pkg::cmd_t     cmd,
	output logic                done,
	output rwset_pkg::rsp_t     result,
	output rwset_pkg::mem_req_t mem_req,
	input  rwset_pkg::entry_t   mem_rdata
);
	import rwset_pkg::*;
	`include "txn_read_write_set_tracker_macros.svh"

	state_t           state_q, state_d;
	logic [2:0]       op_q;
	logic [KEY_W-1:0] key_q;
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] slot_q;
	logic             found_q;
	kind_t            before_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] ins_q;
	logic             wrote_q;
	logic             done_q;
	rsp_t             result_q;

	logic             hit;
	logic             last;

	// decision outputs
	kind_t            after;
	logic             added;
	err_t             err;
	logic             wr;
	logic [IDX_W-1:0] waddr;
	logic [CNT_W-1:0] cnt_d;
	logic [CNT_W-1:0] ins_d;
	logic             wrote_d;

	assign hit  = (mem_rdata.key == key_q);
	assign last = ((CNT_W'(idx_q) + CNT_W'(1)) == cnt_q);

	// next state and RAM ports
	always_comb begin
		state_d            = state_q;
		mem_req.re         = 1'b0;
		mem_req.raddr      = '0;
		mem_req.we         = wr && (state_q == ST_DECIDE);
		mem_req.waddr      = waddr;
		mem_req.wdata.key  = key_q;
		mem_req.wdata.kind = after;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					mem_req.re = 1'b1;
					state_d    = (cnt_q == '0) ? ST_DECIDE : ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				if (hit || last) begin
					state_d = ST_DECIDE;
				end else begin
					mem_req.re    = 1'b1;
					mem_req.raddr = idx_q + IDX_W'(1);
				end
			end
			ST_DECIDE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// kind transition
	always_comb begin
		after   = before_q;
		added   = 1'b0;
		err     = ERR_NONE;
		wr      = 1'b0;
		waddr   = slot_q;
		cnt_d   = cnt_q;
		ins_d   = ins_q;
		wrote_d = wrote_q;
		case (op_q) inside
			OP_CLEAR: begin
				after   = KIND_ABSENT;
				cnt_d   = '0;
				ins_d   = '0;
				wrote_d = 1'b1;
			end
			OP_READ, OP_UPDATE, OP_INSERT, OP_DELETE: begin
				if (!found_q) begin
					if (cnt_q >= CNT_W'(SET_CAPACITY)) begin
						err = ERR_FULL;
					end else begin
						case (op_q)
							OP_READ:   after = KIND_READ;
							OP_UPDATE: after = KIND_UPDATE;
							OP_INSERT: after = KIND_INSERT;
							default:   after = KIND_DELETE;
						endcase
						added = 1'b1;
						wr    = 1'b1;
						waddr = cnt_q[IDX_W-1:0];
						cnt_d = cnt_q + CNT_W'(1);
						if (op_q == OP_INSERT) begin
							ins_d = ins_q + CNT_W'(1);
						end
					end
				end else begin
					case (op_q)
						OP_READ: begin
							if (before_q == KIND_DELETE || before_q == KIND_INS_DEL) begin
								err = ERR_ILLEGAL;
							end
						end
						OP_UPDATE: begin
							case (before_q) inside
								KIND_READ, KIND_READ_OWN: begin
									after   = KIND_UPDATE;
									wrote_d = 1'b1;
								end
								KIND_UPDATE, KIND_INSERT: ;
								default: err = ERR_ILLEGAL;
							endcase
						end
						OP_INSERT: begin
							err = ERR_ILLEGAL;
						end
						default: begin
							case (before_q) inside
								KIND_READ, KIND_READ_OWN: begin
									after   = KIND_DELETE;
									wrote_d = 1'b1;
								end
								KIND_UPDATE: after = KIND_DELETE;
								KIND_INSERT: begin
									after = KIND_INS_DEL;
									added = 1'b1;
									if (ins_q != '0) begin
										ins_d = ins_q - CNT_W'(1);
									end
								end
								KIND_DELETE: ;
								default: err = ERR_ILLEGAL;
							endcase
						end
					endcase
					wr = (err == ERR_NONE);
				end
			end
			default: ;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			found_q <= 1'b0;
			cnt_q   <= '0;
			ins_q   <= '0;
			wrote_q <= 1'b1;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == ST_DECIDE);
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						idx_q   <= '0;
						found_q <= 1'b0;
					end
				end
				ST_SEARCH: begin
					if (hit) begin
						found_q <= 1'b1;
					end else if (!last) begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				ST_DECIDE: begin
					cnt_q   <= cnt_d;
					ins_q   <= ins_d;
					wrote_q <= wrote_d;
				end
				default: ;
			endcase
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			op_q     <= cmd.op;
			key_q    <= cmd.record_key;
			before_q <= KIND_ABSENT;
		end
		if (state_q == ST_SEARCH && hit) begin
			slot_q   <= idx_q;
			before_q <= mem_rdata.kind;
		end
		if (state_q == ST_DECIDE) begin
			result_q.added           <= added;
			result_q.kind_before     <= before_q;
			result_q.kind_after      <= after;
			result_q.error_code      <= err;
			result_q.inserts_pending <= 7'(ins_d);
			result_q.written_flag    <= wrote_d;
		end
	end

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

	`RWSET_ASSERT_NEXT(a_done_after_decide, state_q == ST_DECIDE, done_q && !busy, "no result after decide")
	`RWSET_ASSERT_NOW(a_probe_in_range, state_q == ST_SEARCH, CNT_W'(idx_q) < cnt_q, "probe past fill count")
	`RWSET_ASSERT_NOW(a_ins_le_cnt, 1'b1, ins_q <= cnt_q, "insert count above entry count")
	`RWSET_ASSERT_NOW(a_err_no_change, done_q && result_q.error_code != ERR_NONE, result_q.kind_after == result_q.kind_before && !result_q.added, "error result changed kind")

endmodule

>>> tb/access_set_check_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// access_set_check_pkg
// Scoreboard for the read/write set tracker: predicts each transaction's
// outcome from its own copy of the set and checks the block's results in order.
// ----------------------------------------------------------------------------
package access_set_check_pkg;

	import rwset_pkg::*;

	class access_set_scoreboard;

		logic [KEY_W-1:0] keys [SET_CAPACITY];
		kind_t            kinds [SET_CAPACITY];
		int               fill;
		int               insert_cnt;
		logic             wrote;
		rsp_t             expected_outcomes [$];
		int               errors;
		int               checked;
		int               illegal_seen;
		int               full_seen;

		function new();
			fill         = 0;
			insert_cnt   = 0;
			wrote        = 1'b1;
			errors       = 0;
			checked      = 0;
			illegal_seen = 0;
			full_seen    = 0;
		endfunction

		function int pending();
			return expected_outcomes.size();
		endfunction

		// Apply one accepted transaction to the shadow set, queue its outcome.
		function void note_access(cmd_t c);
			int    slot;
			rsp_t  r;
			kind_t fresh;
			slot = -1;
			for (int i = 0; i < fill; i++)
				if (slot < 0 && keys[i] == c.record_key)
					slot = i;
			r.added       = 1'b0;
			r.error_code  = ERR_NONE;
			r.kind_before = (slot >= 0) ? kinds[slot] : KIND_ABSENT;
			r.kind_after  = r.kind_before;
			case (c.op) inside
				OP_CLEAR: begin
					fill         = 0;
					insert_cnt   = 0;
					wrote        = 1'b1;
					r.kind_after = KIND_ABSENT;
				end
				OP_READ, OP_UPDATE, OP_INSERT, OP_DELETE: begin
					if (slot < 0) begin
						if (fill >= SET_CAPACITY) begin
							r.error_code = ERR_FULL;
						end else begin
							case (c.op)
								OP_READ:   fresh = KIND_READ;
								OP_UPDATE: fresh = KIND_UPDATE;
								OP_INSERT: fresh = KIND_INSERT;
								default:   fresh = KIND_DELETE;
							endcase
							keys[fill]  = c.record_key;
							kinds[fill] = fresh;
							fill++;
							if (c.op == OP_INSERT)
								insert_cnt++;
							r.kind_after = fresh;
							r.added      = 1'b1;
						end
					end else begin
						case (c.op)
							OP_READ: begin
								if (r.kind_before == KIND_DELETE || r.kind_before == KIND_INS_DEL)
									r.error_code = ERR_ILLEGAL;
							end
							OP_UPDATE: begin
								case (r.kind_before) inside
									KIND_READ, KIND_READ_OWN: begin
										r.kind_after = KIND_UPDATE;
										wrote        = 1'b1;
									end
									KIND_UPDATE, KIND_INSERT: ;
									default: r.error_code = ERR_ILLEGAL;
								endcase
							end
							OP_INSERT: r.error_code = ERR_ILLEGAL;
							default: begin
								case (r.kind_before) inside
									KIND_READ, KIND_READ_OWN: begin
										r.kind_after = KIND_DELETE;
										wrote        = 1'b1;
									end
									KIND_UPDATE: r.kind_after = KIND_DELETE;
									KIND_INSERT: begin
										r.kind_after = KIND_INS_DEL;
										if (insert_cnt > 0)
											insert_cnt--;
										r.added = 1'b1;
									end
									KIND_DELETE: ;
									default: r.error_code = ERR_ILLEGAL;
								endcase
							end
						endcase
						if (r.error_code == ERR_NONE)
							kinds[slot] = r.kind_after;
						else
							r.kind_after = r.kind_before;
					end
				end
				default: ;	// query and the spare codes
			endcase
			r.inserts_pending = 7'(insert_cnt);
			r.written_flag    = wrote;
			expected_outcomes.push_back(r);
		endfunction

		function void check_outcome(rsp_t got);
			rsp_t want;
			if (expected_outcomes.size() == 0) begin
				$error("result with no transaction outstanding: %p", got);
				errors++;
				return;
			end
			want = expected_outcomes.pop_front();
			checked++;
			if (want.error_code == ERR_ILLEGAL)
				illegal_seen++;
			if (want.error_code == ERR_FULL)
				full_seen++;
			if (got.added !== want.added) begin
				$error("added: expected %0d, got %0d", want.added, got.added);
				errors++;
			end
			if (got.kind_before !== want.kind_before) begin
				$error("kind_before: expected %0d, got %0d", want.kind_before, got.kind_before);
				errors++;
			end
			if (got.kind_after !== want.kind_after) begin
				$error("kind_after: expected %0d, got %0d", want.kind_after, got.kind_after);
				errors++;
			end
			if (got.error_code !== want.error_code) begin
				$error("error_code: expected %0d, got %0d", want.error_code, got.error_code);
				errors++;
			end
			if (got.inserts_pending !== want.inserts_pending) begin
				$error("inserts_pending: expected %0d, got %0d",
					want.inserts_pending, got.inserts_pending);
				errors++;
			end
			if (got.written_flag !== want.written_flag) begin
				$error("written_flag: expected %0d, got %0d", want.written_flag, got.written_flag);
				errors++;
			end
		endfunction

	endclass

endpackage

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives query/read/update/insert/delete/clear transactions into the set
// tracker: a directed walk through every kind transition, then random
// episodes over small and overfull key pools, checked by a scoreboard.
// ----------------------------------------------------------------------------
module tb_top;

	import rwset_pkg::*;
	import access_set_check_pkg::*;

	// Spare op codes; the block treats them as a query.
	localparam logic [2:0] OP_SPARE_LO = 3'd6;
	localparam logic [2:0] OP_SPARE_HI = 3'd7;

	localparam int RANDOM_TXNS = 1850;
	localparam int QUIET_TAIL  = 200;                // last transactions go back to back
	localparam int TAIL_CYCLES = SET_CAPACITY + 8;   // worst probe count plus margin
	localparam int CYCLE_LIMIT = 1_000_000;          // well above the worst-case run length

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	cmd_t cmd;
	logic done;
	rsp_t result;

	access_set_scoreboard sb;
	int                   cycle_count = 0;
	int                   txn_sent    = 0;
	int                   quiet_from  = 32'h7fff_ffff;
	int                   gap_pct     = 20;
	logic [KEY_W-1:0]     key_pool [$];

	txn_read_write_set_tracker dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.result (result)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Monitor. A result at this edge belongs to an older transaction than
	// one accepted at the same edge, so check before noting.
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				sb.check_outcome(result);
			if (start && !busy)
				sb.note_access(cmd);
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d transactions outstanding",
				cycle_count, sb.pending());
			$display("Verification failed");
			$finish;
		end
	end

	// Sender idles with start low; cmd is scrambled meanwhile since the block
	// must ignore it while start is low.
	task automatic idle_cycles(input int n);
		repeat (n) begin
			@(negedge clk);
			start <= 1'b0;
			cmd   <= {3'($urandom), $urandom, $urandom};
		end
	endtask

	// Hold off until every outstanding transaction has returned its result.
	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
	endtask

	// One transaction: optional idle burst, then hold start until accepted.
	task automatic send_access(input logic [2:0] op, input logic [KEY_W-1:0] key);
		if (txn_sent < quiet_from && $urandom_range(0, 99) < gap_pct)
			idle_cycles($urandom_range(1, 12));
		@(negedge clk);
		start <= 1'b1;
		cmd   <= '{op: op, record_key: key};
		do
			@(posedge clk);
		while (busy);
		txn_sent++;
	endtask

	// Mostly random keys, with the all-zero and all-one corners now and then.
	function automatic logic [KEY_W-1:0] rand_key();
		case ($urandom_range(0, 15))
			0:       return '0;
			1:       return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// Op mix leaning on reads and deletes, which drive most transitions.
	function automatic logic [2:0] pick_op();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)      return OP_QUERY;
		else if (r < 40) return OP_READ;
		else if (r < 60) return OP_UPDATE;
		else if (r < 75) return OP_INSERT;
		else if (r < 95) return OP_DELETE;
		else if (r < 97) return OP_CLEAR;
		else             return $urandom_range(0, 1) ? OP_SPARE_LO : OP_SPARE_HI;
	endfunction

	// One episode = one database transaction's worth of accesses. Small pools
	// give many hits and upgrades; overfull pools sweep past capacity so the
	// table-full path is taken; noise episodes use any op on any key.
	task automatic run_episode();
		int               mode;
		int               n;
		int               len;
		logic [KEY_W-1:0] k;
		mode    = $urandom_range(0, 9);
		gap_pct = $urandom_range(0, 2) * 15;
		if (mode == 0) begin
			len = $urandom_range(5, 20);
			for (int i = 0; i < len; i++)
				send_access(3'($urandom), rand_key());
			return;
		end
		key_pool.delete();
		n = (mode == 1) ? $urandom_range(SET_CAPACITY + 1, SET_CAPACITY + 12)
		                : $urandom_range(1, 16);
		for (int i = 0; i < n; i++) begin
			// neighbors one bit apart stress the key compare
			if (i > 0 && $urandom_range(0, 3) == 0)
				k = key_pool[i-1] ^ (64'd1 << $urandom_range(0, 63));
			else
				k = rand_key();
			key_pool.push_back(k);
		end
		// usually start from an empty set; otherwise carry over prior state
		if ($urandom_range(0, 3) != 0)
			send_access(OP_CLEAR, key_pool[$urandom_range(0, n - 1)]);
		if (mode == 1)
			for (int i = 0; i < n; i++)
				send_access(3'($urandom_range(OP_READ, OP_DELETE)), key_pool[i]);
		len = $urandom_range(5, 40);
		for (int i = 0; i < len; i++)
			send_access(pick_op(), key_pool[$urandom_range(0, n - 1)]);
		if (txn_sent < quiet_from && $urandom_range(0, 7) == 0)
			drain();
	endtask

	initial begin
		logic [KEY_W-1:0] kb;
		logic [KEY_W-1:0] kc;
		logic [KEY_W-1:0] kd;
		int               txn_target;
		sb     = new();
		arst_n = 1'b0;
		start  = 1'b0;
		cmd    = '0;
		kb     = {$urandom, $urandom};
		kc     = {$urandom, $urandom};
		kd     = {$urandom, $urandom};
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		// Directed: query of an absent key, then read -> update -> delete on
		// the all-ones key, with repeats and the illegal follow-ups.
		send_access(OP_QUERY,  '0);
		send_access(OP_READ,   '1);
		send_access(OP_READ,   '1);
		send_access(OP_UPDATE, '1);
		send_access(OP_UPDATE, '1);
		send_access(OP_DELETE, '1);
		send_access(OP_DELETE, '1);
		send_access(OP_READ,   '1);
		send_access(OP_UPDATE, '1);
		send_access(OP_INSERT, '1);
		send_access(OP_QUERY,  '1);
		// insert path on the zero key: insert then delete gives ins_del
		send_access(OP_INSERT, '0);
		send_access(OP_UPDATE, '0);
		send_access(OP_READ,   '0);
		send_access(OP_DELETE, '0);
		send_access(OP_READ,   '0);
		send_access(OP_UPDATE, '0);
		send_access(OP_DELETE, '0);
		// fresh update and delete entries, read upgraded to delete
		send_access(OP_UPDATE, kb);
		send_access(OP_DELETE, kb);
		send_access(OP_DELETE, kc);
		send_access(OP_READ,   kd);
		send_access(OP_DELETE, kd);
		// spare codes act as a query; clear reports the key's prior kind
		send_access(OP_SPARE_LO, kd);
		send_access(OP_SPARE_HI, kd);
		send_access(OP_CLEAR,    kd);

		// sender waits for the block to go fully quiet at least once
		drain();

		txn_target = txn_sent + RANDOM_TXNS;
		quiet_from = txn_target - QUIET_TAIL;
		while (txn_sent < txn_target)
			run_episode();

		@(negedge clk);
		start <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Ran %0d transactions, %0d results checked, %0d mismatches.",
			txn_sent, sb.checked, sb.errors);
		$display("Covered %0d illegal transitions and %0d table-full refusals.",
			sb.illegal_seen, sb.full_seen);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
